// File: design/alm_pkg.sv
// Shared types, constants and breakpoint tables for the audio level bar meter.
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + 1;
  localparam int DB_STEPS    = 6 * SAMPLE_BITS;
  localparam int BAR_ROWS    = 6 * SAMPLE_BITS;
  localparam int CNT_BITS    = $clog2(DB_STEPS + 1);
  localparam int LIMIT_BITS  = 8;
  localparam int CFG_DATA_BITS = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CLASS_BITS  = 3;
  localparam int BAR_BITS    = 7;

  localparam int LOG_EXP     = 20;
  localparam int BAR_EXP     = 6;
  localparam int DB_POW2     = LOG_EXP * SAMPLE_BITS;
  localparam int DB_WIDE     = 2 * DB_POW2 + 64;
  localparam int BAR_WIDE    = BAR_EXP * SAMPLE_BITS + 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_SILENCE_LIMIT = 3'd1,
    REG_QUIET_LIMIT   = 3'd2,
    REG_LOUD_LIMIT    = 3'd3,
    REG_TOP_LIMIT     = 3'd4
  } reg_index_t;

  typedef enum logic [CLASS_BITS-1:0] {
    CLASS_SILENCE  = 3'd0,
    CLASS_QUIET    = 3'd1,
    CLASS_LOUD     = 3'd2,
    CLASS_NEAR_MAX = 3'd3,
    CLASS_OVER_MAX = 3'd4
  } colour_class_t;

  localparam logic [3:0]                   RST_CHANNEL_COUNT = 4'd2;
  localparam logic signed [LIMIT_BITS-1:0] RST_SILENCE_LIMIT = -8'sd72;
  localparam logic signed [LIMIT_BITS-1:0] RST_QUIET_LIMIT   = -8'sd60;
  localparam logic signed [LIMIT_BITS-1:0] RST_LOUD_LIMIT    = -8'sd12;
  localparam logic signed [LIMIT_BITS-1:0] RST_TOP_LIMIT     = -8'sd3;

  typedef struct packed {
    logic [3:0]                   channel_count;
    logic signed [LIMIT_BITS-1:0] silence_limit;
    logic signed [LIMIT_BITS-1:0] quiet_limit;
    logic signed [LIMIT_BITS-1:0] loud_limit;
    logic signed [LIMIT_BITS-1:0] top_limit;
  } cfg_t;

  // true when s^20 * 10^n <= 2^320, exact wide integer math at elaboration
  function automatic logic db_fits(input logic [SUM_BITS-1:0] s, input int n);
    logic [DB_WIDE-1:0] p;
    logic [DB_WIDE-1:0] lim;
    p   = DB_WIDE'(1);
    lim = DB_WIDE'(1) << DB_POW2;
    for (int j = 0; j < LOG_EXP; j++) begin
      p = p * DB_WIDE'(s);
    end
    for (int j = 0; j < n; j++) begin
      p = p * DB_WIDE'(10);
    end
    return p <= lim;
  endfunction

  // true when s^6 <= 2^k
  function automatic logic bar_fits(input logic [SUM_BITS-1:0] s, input int k);
    logic [BAR_WIDE-1:0] p;
    p = BAR_WIDE'(1);
    for (int j = 0; j < BAR_EXP; j++) begin
      p = p * BAR_WIDE'(s);
    end
    return p <= (BAR_WIDE'(1) << k);
  endfunction

  // floor(2^16 * 10^(-(idx+1)/20)) by binary search
  function automatic logic [SUM_BITS-1:0] db_edge(input int idx);
    logic [SUM_BITS-1:0] lo;
    logic [SUM_BITS-1:0] hi;
    logic [SUM_BITS-1:0] mid;
    lo = SUM_BITS'(1);
    hi = SUM_BITS'(1) << SAMPLE_BITS;
    for (int b = 0; b < SUM_BITS + 1; b++) begin
      if (hi - lo > SUM_BITS'(1)) begin
        mid = SUM_BITS'((lo + hi) >> 1);
        if (db_fits(mid, idx + 1)) lo = mid;
        else hi = mid;
      end
    end
    return lo;
  endfunction

  // floor(2^(idx/6)) by binary search
  function automatic logic [SUM_BITS-1:0] bar_edge(input int idx);
    logic [SUM_BITS-1:0] lo;
    logic [SUM_BITS-1:0] hi;
    logic [SUM_BITS-1:0] mid;
    lo = SUM_BITS'(1);
    hi = SUM_BITS'(1) << SAMPLE_BITS;
    for (int b = 0; b < SUM_BITS + 1; b++) begin
      if (hi - lo > SUM_BITS'(1)) begin
        mid = SUM_BITS'((lo + hi) >> 1);
        if (bar_fits(mid, idx)) lo = mid;
        else hi = mid;
      end
    end
    return lo;
  endfunction

endpackage

`default_nettype wire

// File: design/alm_cfg_regs.sv
// Configuration register file: channel count and the four dB limits.
`timescale 1ns / 1ps
`default_nettype none

module alm_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [alm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [alm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output alm_pkg::cfg_t                             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= alm_pkg::RST_CHANNEL_COUNT;
      cfg.silence_limit <= alm_pkg::RST_SILENCE_LIMIT;
      cfg.quiet_limit   <= alm_pkg::RST_QUIET_LIMIT;
      cfg.loud_limit    <= alm_pkg::RST_LOUD_LIMIT;
      cfg.top_limit     <= alm_pkg::RST_TOP_LIMIT;
    end else if (cfg_we) begin
      case (alm_pkg::reg_index_t'(cfg_index))
        alm_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[3:0];
        alm_pkg::REG_SILENCE_LIMIT: cfg.silence_limit <= cfg_data;
        alm_pkg::REG_QUIET_LIMIT:   cfg.quiet_limit   <= cfg_data;
        alm_pkg::REG_LOUD_LIMIT:    cfg.loud_limit    <= cfg_data;
        alm_pkg::REG_TOP_LIMIT:     cfg.top_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/alm_front.sv
// Input stage: sample magnitudes, mono handling, sum register.
`timescale 1ns / 1ps
`default_nettype none

module alm_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic signed [alm_pkg::SAMPLE_BITS-1:0] first_sample,
  input  wire logic signed [alm_pkg::SAMPLE_BITS-1:0] second_sample,
  input  wire logic [3:0]                          channel_count,
  input  wire logic                                take,
  output      logic                                sum_valid,
  output      logic [alm_pkg::SUM_BITS-1:0]        sum
);

  logic [alm_pkg::SUM_BITS-1:0] left_mag;
  logic [alm_pkg::SUM_BITS-1:0] right_mag;
  logic [alm_pkg::SUM_BITS-1:0] sum_next;
  logic                         load;

  function automatic logic [alm_pkg::SUM_BITS-1:0] mag(
    input logic [alm_pkg::SAMPLE_BITS-1:0] v
  );
    logic [alm_pkg::SUM_BITS-1:0] ext;
    ext = {1'b0, v};
    return v[alm_pkg::SAMPLE_BITS-1] ?
      (alm_pkg::SUM_BITS'(1) << alm_pkg::SAMPLE_BITS) - ext : ext;
  endfunction

  always_comb begin
    left_mag  = mag(first_sample);
    right_mag = (channel_count > 4'd1) ? mag(second_sample) : left_mag;
    sum_next  = left_mag + right_mag;
    if (sum_next == '0) sum_next = alm_pkg::SUM_BITS'(1);
  end

  assign in_ready = !sum_valid || take;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (in_ready) begin
      sum_valid <= in_valid;
    end
    if (load) sum <= sum_next;
  end

endmodule

`default_nettype wire

// File: design/alm_back.sv
// Result stage: breakpoint compare banks, colour class, result register.
`timescale 1ns / 1ps
`default_nettype none

module alm_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sum_valid,
  input  wire logic [alm_pkg::SUM_BITS-1:0]        sum,
  input  wire alm_pkg::cfg_t                       cfg,
  output      logic                                take,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [alm_pkg::LIMIT_BITS-1:0] level_db,
  output      logic [alm_pkg::CLASS_BITS-1:0]      colour_class,
  output      logic [alm_pkg::BAR_BITS-1:0]        bar_top
);

  logic [alm_pkg::DB_STEPS-1:0]    db_gt;
  logic [alm_pkg::BAR_ROWS-2:0]    bar_gt;
  logic [alm_pkg::CNT_BITS-1:0]    db_cnt;
  logic [alm_pkg::BAR_BITS-1:0]    bar_next;
  logic signed [alm_pkg::LIMIT_BITS-1:0] level_next;
  alm_pkg::colour_class_t          class_next;

  for (genvar g = 0; g < alm_pkg::DB_STEPS; g++) begin : g_db
    localparam logic [alm_pkg::SUM_BITS-1:0] EDGE = alm_pkg::db_edge(g);
    assign db_gt[g] = sum > EDGE;
  end

  for (genvar g = 0; g < alm_pkg::BAR_ROWS - 1; g++) begin : g_bar
    localparam logic [alm_pkg::SUM_BITS-1:0] EDGE = alm_pkg::bar_edge(g);
    assign bar_gt[g] = sum > EDGE;
  end

  always_comb begin
    db_cnt     = alm_pkg::CNT_BITS'($countones(db_gt));
    bar_next   = alm_pkg::BAR_BITS'($countones(bar_gt));
    level_next = alm_pkg::LIMIT_BITS'(db_cnt) - alm_pkg::LIMIT_BITS'(alm_pkg::DB_STEPS);
    priority if (level_next <= cfg.silence_limit) class_next = alm_pkg::CLASS_SILENCE;
    else if (level_next <= cfg.quiet_limit)       class_next = alm_pkg::CLASS_QUIET;
    else if (level_next <= cfg.loud_limit)        class_next = alm_pkg::CLASS_LOUD;
    else if (level_next <= cfg.top_limit)         class_next = alm_pkg::CLASS_NEAR_MAX;
    else                                          class_next = alm_pkg::CLASS_OVER_MAX;
  end

  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= sum_valid;
    end
    if (take && sum_valid) begin
      level_db     <= level_next;
      colour_class <= class_next;
      bar_top      <= bar_next;
    end
  end

endmodule

`default_nettype wire

// File: design/audio_level_bar_meter_top.sv
// Audio level bar meter: dB level, colour class and bar height per frame.
// Path from input accept to result valid: sum register, then result register.
// Throughput: 1 item per cycle while out_ready stays high.
// Ready propagates back from out_ready through both stages.
// Reset (rst, synchronous): pipeline emptied, registers at channel_count 2 and
// limits -72, -60, -12, -3 dB.
`timescale 1ns / 1ps
`default_nettype none

module audio_level_bar_meter_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [alm_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [alm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                                   in_valid,
  output      logic                                   in_ready,
  input  wire logic signed [alm_pkg::SAMPLE_BITS-1:0] first_sample,
  input  wire logic signed [alm_pkg::SAMPLE_BITS-1:0] second_sample,
  output      logic                                   out_valid,
  input  wire logic                                   out_ready,
  output      logic signed [alm_pkg::LIMIT_BITS-1:0]  level_db,
  output      logic [alm_pkg::CLASS_BITS-1:0]         colour_class,
  output      logic [alm_pkg::BAR_BITS-1:0]           bar_top
);

  alm_pkg::cfg_t                cfg;
  logic                         take;
  logic                         sum_valid;
  logic [alm_pkg::SUM_BITS-1:0] sum;

  alm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  alm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .first_sample  (first_sample),
    .second_sample (second_sample),
    .channel_count (cfg.channel_count),
    .take          (take),
    .sum_valid     (sum_valid),
    .sum           (sum)
  );

  alm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum          (sum),
    .cfg          (cfg),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .level_db     (level_db),
    .colour_class (colour_class),
    .bar_top      (bar_top)
  );

  // a stalled item holds its result fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(level_db)
                                   && $stable(colour_class) && $stable(bar_top)))
    else $error("result changed while stalled");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_db <= 8'sd0 && level_db >= -8'sd96))
    else $error("level_db out of range");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (colour_class <= alm_pkg::CLASS_OVER_MAX))
    else $error("colour_class out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!sum_valid && !out_valid) |-> in_ready)
    else $error("empty pipeline not ready");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && take) |=> out_valid)
    else $error("item lost between stages");

endmodule

`default_nettype wire

// File: tb/sv/alm_meter_checker.sv
// Checker for the audio level bar meter: predicts each reading from the accepted frame.
`timescale 1ns / 1ps

module alm_meter_checker
  import alm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] first_sample,
  input  logic signed [SAMPLE_BITS-1:0] second_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [LIMIT_BITS-1:0]  level_db,
  input  logic [CLASS_BITS-1:0]         colour_class,
  input  logic [BAR_BITS-1:0]           bar_top,
  output int                            mismatches,
  output int                            readings_pending
);

  localparam int POWER_BITS = 704;
  localparam int ROW_POWER_BITS = 112;

  typedef struct {
    logic signed [LIMIT_BITS-1:0] level;
    colour_class_t                shade;
    logic [BAR_BITS-1:0]          bar;
  } meter_reading_t;

  cfg_t           settings;
  meter_reading_t readings_due[$];
  meter_reading_t due;
  int             readings_checked;

  function automatic int magnitude_of(logic signed [SAMPLE_BITS-1:0] v);
    int x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function automatic meter_reading_t predict_reading(logic signed [SAMPLE_BITS-1:0] a,
                                                     logic signed [SAMPLE_BITS-1:0] b,
                                                     cfg_t s);
    meter_reading_t          r;
    int                      sum;
    int                      db;
    int                      rows;
    logic [POWER_BITS-1:0]     p;
    logic [POWER_BITS-1:0]     full_scale_pow;
    logic [ROW_POWER_BITS-1:0] q;
    sum = magnitude_of(a) + ((s.channel_count > 4'd1) ? magnitude_of(b) : magnitude_of(a));
    if (sum == 0) sum = 1;
    // ceil(20*log10(sum/2^16)) = -96 + #{n in 1..96 : sum^20 * 10^n > 2^320}
    p = POWER_BITS'(1);
    for (int i = 0; i < LOG_EXP; i++) p = p * POWER_BITS'(sum);
    full_scale_pow = POWER_BITS'(1) << DB_POW2;
    db = -DB_STEPS;
    for (int n = 1; n <= DB_STEPS; n++) begin
      p = p * POWER_BITS'(10);
      if (p > full_scale_pow) db++;
    end
    // bar rows: #{k in 0..94 : sum^6 > 2^k}
    q = ROW_POWER_BITS'(1);
    for (int i = 0; i < BAR_EXP; i++) q = q * ROW_POWER_BITS'(sum);
    rows = 0;
    for (int k = 0; k < BAR_ROWS - 1; k++) begin
      if (q > (ROW_POWER_BITS'(1) << k)) rows++;
    end
    if (db <= $signed(s.silence_limit)) r.shade = CLASS_SILENCE;
    else if (db <= $signed(s.quiet_limit)) r.shade = CLASS_QUIET;
    else if (db <= $signed(s.loud_limit)) r.shade = CLASS_LOUD;
    else if (db <= $signed(s.top_limit)) r.shade = CLASS_NEAR_MAX;
    else r.shade = CLASS_OVER_MAX;
    r.level = LIMIT_BITS'(db);
    r.bar = BAR_BITS'(rows);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings = '{RST_CHANNEL_COUNT, RST_SILENCE_LIMIT, RST_QUIET_LIMIT,
                   RST_LOUD_LIMIT, RST_TOP_LIMIT};
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_CHANNEL_COUNT: settings.channel_count = cfg_data[3:0];
          REG_SILENCE_LIMIT: settings.silence_limit = cfg_data;
          REG_QUIET_LIMIT:   settings.quiet_limit = cfg_data;
          REG_LOUD_LIMIT:    settings.loud_limit = cfg_data;
          REG_TOP_LIMIT:     settings.top_limit = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected reading: level %0d class %0d bar %0d",
                     $time, level_db, colour_class, bar_top);
          mismatches = mismatches + 1;
        end else begin
          due = readings_due.pop_front();
          if (level_db !== due.level || colour_class !== due.shade || bar_top !== due.bar) begin
            if (mismatches < 10)
              $display("%0t: reading %0d: expected level %0d class %0d bar %0d, got %0d %0d %0d",
                       $time, readings_checked, due.level, due.shade, due.bar,
                       level_db, colour_class, bar_top);
            mismatches = mismatches + 1;
          end
          readings_checked++;
        end
      end
      if (in_valid && in_ready)
        readings_due.push_back(predict_reading(first_sample, second_sample, settings));
    end
    readings_pending <= readings_due.size();
  end

endmodule

// File: tb/sv/audio_level_bar_meter_top_test.sv
// Testbench top for the audio level bar meter: frame stimulus, register phases and verdict.
`timescale 1ns / 1ps

module audio_level_bar_meter_top_test;
  import alm_pkg::*;

  localparam int RANDOM_PHASES = 6;
  localparam int FRAMES_PER_PHASE = 185;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index = REG_CHANNEL_COUNT;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] first_sample = '0;
  logic signed [SAMPLE_BITS-1:0] second_sample = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [LIMIT_BITS-1:0]  level_db;
  logic [CLASS_BITS-1:0]         colour_class;
  logic [BAR_BITS-1:0]           bar_top;
  int                            mismatches;
  int                            readings_pending;
  int                            sender_gap_pct = 0;
  int                            ready_stall_pct = 0;

  audio_level_bar_meter_top dut (.*);

  alm_meter_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= ready_stall_pct);
  end

  task automatic send_frame(input int a, input int b);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_sample <= SAMPLE_BITS'(a);
    second_sample <= SAMPLE_BITS'(b);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_meter;
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    cfg_we <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data <= {4'b0, s.channel_count};
    @(posedge clk);
    cfg_index <= REG_SILENCE_LIMIT;
    cfg_data <= s.silence_limit;
    @(posedge clk);
    cfg_index <= REG_QUIET_LIMIT;
    cfg_data <= s.quiet_limit;
    @(posedge clk);
    cfg_index <= REG_LOUD_LIMIT;
    cfg_data <= s.loud_limit;
    @(posedge clk);
    cfg_index <= REG_TOP_LIMIT;
    cfg_data <= s.top_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_sample;
    int v;
    case ($urandom_range(3))
      0, 1: v = int'($urandom_range(65535)) - 32768;
      2: begin
        // small magnitudes reach the low end of the dB scale
        v = int'($urandom_range(1 << $urandom_range(15)));
        if ($urandom_range(1) == 1) v = -v;
        if (v > 32767) v = -32768;
      end
      default: begin
        case ($urandom_range(4))
          0: v = 0;
          1: v = 1;
          2: v = -1;
          3: v = 32767;
          default: v = -32768;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic cfg_t random_settings;
    cfg_t s;
    int   edge_db;
    s.channel_count = 4'($urandom_range(15));
    if ($urandom_range(3) == 0) begin
      s.silence_limit = 8'($urandom);
      s.quiet_limit = 8'($urandom);
      s.loud_limit = 8'($urandom);
      s.top_limit = 8'($urandom);
    end else begin
      edge_db = -100 + int'($urandom_range(40));
      s.silence_limit = 8'(edge_db);
      edge_db = edge_db + int'($urandom_range(30));
      s.quiet_limit = 8'(edge_db);
      edge_db = edge_db + int'($urandom_range(50));
      s.loud_limit = 8'(edge_db);
      edge_db = edge_db + int'($urandom_range(15));
      s.top_limit = 8'(edge_db);
    end
    return s;
  endfunction

  initial begin : stimulus
    cfg_t phase_settings;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings, stereo
    send_frame(0, 0);
    send_frame(-32768, -32768);
    send_frame(32767, 32767);
    send_frame(-32768, 0);
    send_frame(1, 0);
    send_frame(0, -1);
    send_frame(1, 1);
    send_frame(2, 2);
    send_frame(-4, 4);
    send_frame(16384, 16384);
    send_frame(32767, -32768);
    send_frame(29204, 29204);
    send_frame(29204, 29205);
    drain_meter();

    // mono: first sample counts twice
    load_settings('{4'd1, RST_SILENCE_LIMIT, RST_QUIET_LIMIT, RST_LOUD_LIMIT, RST_TOP_LIMIT});
    send_frame(5, 30000);
    send_frame(-32768, 7);
    send_frame(-1, -32768);
    drain_meter();
    load_settings('{4'd0, RST_SILENCE_LIMIT, RST_QUIET_LIMIT, RST_LOUD_LIMIT, RST_TOP_LIMIT});
    send_frame(0, -32768);
    send_frame(123, -1);
    drain_meter();

    // limits no level reaches, and limits every level is under
    load_settings('{4'd2, -8'sd128, -8'sd128, -8'sd128, -8'sd128});
    send_frame(0, 0);
    send_frame(-32768, -32768);
    drain_meter();
    load_settings('{4'd15, 8'sd127, 8'sd127, 8'sd127, 8'sd127});
    send_frame(0, 0);
    send_frame(-32768, -32768);
    send_frame(100, -100);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_meter();
      if (phase == 0)
        phase_settings = '{RST_CHANNEL_COUNT, RST_SILENCE_LIMIT, RST_QUIET_LIMIT,
                           RST_LOUD_LIMIT, RST_TOP_LIMIT};
      else
        phase_settings = random_settings();
      load_settings(phase_settings);
      sender_gap_pct = (phase < 2) ? 34 : (phase < 4) ? 71 : 0;
      ready_stall_pct <= (phase < 2) ? 71 : (phase < 4) ? 34 : 0;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if ($urandom_range(199) == 0) drain_meter();
        send_frame(pick_sample(), pick_sample());
      end
    end
    drain_meter();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
design/alm_pkg.sv
design/alm_cfg_regs.sv
design/alm_front.sv
design/alm_back.sv
design/audio_level_bar_meter_top.sv
tb/sv/alm_meter_checker.sv
tb/sv/audio_level_bar_meter_top_test.sv
